// ----- rtl/isc_pkg.sv -----
// isc_pkg: shared types and constants for the insertion sorter.
// No dependencies; imported by isc_cell, insertion_sorter and the bench.
`default_nettype none

package isc_pkg;

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    // Broadcast control for every cell in the chain
    typedef struct packed {
        logic  insert;     // place new_value into the chain this cycle
        logic  shift;      // move every entry one cell toward the output
        word_t new_value;  // value being inserted
    } isc_ctrl_t;

    // What one cell shows its upper neighbor
    typedef struct packed {
        word_t value;      // held entry
        logic  lt;         // cell is occupied and new_value sorts before it
    } isc_link_t;

endpackage : isc_pkg

`default_nettype wire

// ----- rtl/isc_cell.sv -----
// isc_cell: one slot of the systolic sort chain.
// Depends on isc_pkg for the control and neighbor link types.
`default_nettype none

module isc_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  wire                     aclk,
    input  wire isc_pkg::isc_ctrl_t ctrl,
    input  wire  [CNT_W-1:0]        count,
    input  wire isc_pkg::isc_link_t lower,
    input  wire isc_pkg::word_t     upper_value,
    output isc_pkg::isc_link_t      link
);
    import isc_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    word_t value_reg;
    word_t value_next;
    logic  occupied;
    logic  is_tail;
    logic  lt;

    // Occupancy follows from the fill count; the lowest free cell is the tail
    assign occupied = count > MY_IDX;
    assign is_tail  = count == MY_IDX;
    assign lt       = occupied && (ctrl.new_value < value_reg);

    // On shift, upper entry; on insert, lower if it moves up, else new_value
    always_comb begin
        value_next = value_reg;
        if (ctrl.shift) begin
            value_next = upper_value;
        end else if (ctrl.insert && (lt || is_tail)) begin
            value_next = lower.lt ? lower.value : ctrl.new_value;
        end
    end

    // Hold the entry; no reset on payload
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign link.value = value_reg;
    assign link.lt    = lt;

endmodule : isc_cell

`default_nettype wire

// ----- rtl/insertion_sorter.sv -----
// insertion_sorter: streaming insertion sort over a chain of isc_cell slots.
// Depends on isc_pkg and isc_cell.
//
//  channel | direction | ports                             | request carries
//  --------+-----------+-----------------------------------+-------------------------
//  s_      | in        | s_valid s_ready s_value s_last    | one value, end-of-set
//  m_      | out       | m_valid m_ready m_sorted_value    | next value, largest flag
//          |           | m_final_res                       |
//
// Each accepted request is placed in parallel: every cell compares the new
// value at once and larger entries move up one cell. After the last request of
// a set (or when MAX_LEN values are held) the chain drains through cell 0, one
// result per cycle that m_ready is high; s_ready stays low until it is empty.
// A stalled m_ready holds the chain. Reset empties the chain (count to zero).
`default_nettype none

module insertion_sorter #(
    parameter int MAX_LEN = 64
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire isc_pkg::word_t   s_value,
    input  wire                   s_last,
    output logic                  m_valid,
    input  wire                   m_ready,
    output isc_pkg::word_t        m_sorted_value,
    output logic                  m_final_res
);
    import isc_pkg::*;

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam logic [CNT_W-1:0] FULL_M1 = CNT_W'(MAX_LEN - 1);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             flush_reg;
    logic             flush_next;
    logic             in_fire;
    logic             out_fire;
    isc_ctrl_t        ctrl;
    isc_link_t        links [MAX_LEN];

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    // Broadcast insert and drain controls to every cell
    assign ctrl.insert    = in_fire;
    assign ctrl.shift     = out_fire;
    assign ctrl.new_value = s_value;

    // Build the chain
    for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
        isc_link_t lower;
        word_t     upper_value;
        if (i == 0) begin : g_first
            assign lower.value = '0;
            assign lower.lt    = 1'b0;
        end else begin : g_mid
            assign lower = links[i-1];
        end
        if (i == MAX_LEN - 1) begin : g_top
            assign upper_value = links[i].value;
        end else begin : g_below
            assign upper_value = links[i+1].value;
        end
        isc_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .count       (count_reg),
            .lower       (lower),
            .upper_value (upper_value),
            .link        (links[i])
        );
    end

    // Advance fill count and drain flag
    always_comb begin
        count_next = count_reg;
        flush_next = flush_reg;
        if (in_fire) begin
            count_next = count_reg + ONE;
            if (s_last || count_reg == FULL_M1) begin
                flush_next = 1'b1;
            end
        end else if (out_fire) begin
            count_next = count_reg - ONE;
            if (count_reg == ONE) begin
                flush_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            flush_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            flush_reg <= flush_next;
        end
    end

    // Cell 0 is the output register while draining
    assign s_ready        = !flush_reg;
    assign m_valid        = flush_reg;
    assign m_sorted_value = links[0].value;
    assign m_final_res    = count_reg == ONE;

    // Fill count never passes the chain length
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("fill count beyond chain length");

    // Draining always has something to send
    a_flush_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_reg |-> count_reg != '0)
        else $error("drain with empty chain");

    // End of set starts the drain on the next cycle
    a_last_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_last) |=> m_valid)
        else $error("end of set did not start drain");

    // Final result leaves the chain empty and ready for input
    a_final_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_fire && m_final_res) |=> (count_reg == '0 && s_ready))
        else $error("chain not empty after final result");

endmodule : insertion_sorter

`default_nettype wire

// ----- tb/insertion_sorter_tb.sv -----
// insertion_sorter_tb: self-checking bench for the streaming insertion sorter.
// Depends on isc_pkg and insertion_sorter; predicts each sorted set and checks
// every result request against it, with random idling on both channels.
module insertion_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isc_pkg::*;

    localparam int SORT_DEPTH   = 64;
    localparam int ITEM_TARGET  = 380;
    localparam int SYNC_POINT   = 200;
    localparam int LONG_HOLD_AT = 150;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        word_t value;
        logic  last;
        logic  wait_idle;   // present only once every expected result is in
    } request_t;

    typedef struct {
        word_t value;
        logic  final_res;
    } sorted_t;

    logic  aclk = 1'b0;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    word_t s_value;
    logic  s_last;
    logic  m_valid;
    logic  m_ready;
    word_t m_sorted_value;
    logic  m_final_res;

    request_t    pending[$];
    sorted_t     sorted_due[$];
    word_t       held_vals[$];
    logic        s_taken;
    int unsigned cycle_count;
    int          results_seen;
    int          fault_count;
    int          send_gap;
    int          ready_stall;
    logic        long_hold_done;

    insertion_sorter #(
        .MAX_LEN(SORT_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_final_res   (m_final_res)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Insert a value after any equal entries; release the set on end or full
    function automatic void sort_insert(word_t v, logic end_of_set);
        int pos;
        pos = held_vals.size();
        while (pos > 0 && v < held_vals[pos-1])
            pos--;
        held_vals.insert(pos, v);
        if (end_of_set || held_vals.size() == SORT_DEPTH) begin
            foreach (held_vals[k])
                sorted_due.push_back('{held_vals[k], k == held_vals.size() - 1});
            held_vals.delete();
        end
    endfunction

    // Mostly short gaps, a few long ones, and quiet windows with none
    function automatic int idle_gap();
        int r;
        if (cycle_count % 512 < 96)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    // Bias toward extremes and a narrow band that yields duplicates
    function automatic word_t pick_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(WORD_W-1){1'b0}}};
            1: return {1'b0, {(WORD_W-1){1'b1}}};
            2: return '0;
            3: return '1;
            4, 5: return word_t'($signed($urandom_range(0, 15)) - 8);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic void add_request(word_t v, logic l, logic w);
        pending.push_back('{v, l, w});
    endfunction

    // Sample both channels: predict on accepted input, check accepted results
    always @(posedge aclk) begin : watch_ports
        sorted_t want;
        cycle_count <= cycle_count + 1;
        s_taken     <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            sort_insert(s_value, s_last);
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (sorted_due.size() == 0) begin
                $error("unexpected result: sorted_value=%0d final_res=%b",
                       m_sorted_value, m_final_res);
                fault_count++;
            end else begin
                want = sorted_due.pop_front();
                if (m_sorted_value !== want.value) begin
                    $error("sorted_value: expected %0d, got %0d", want.value, m_sorted_value);
                    fault_count++;
                end
                if (m_final_res !== want.final_res) begin
                    $error("final_res: expected %b, got %b", want.final_res, m_final_res);
                    fault_count++;
                end
            end
        end
    end

    // Drive input requests from the pending queue
    always @(negedge aclk) begin : drive_requests
        request_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (s_taken)
                send_gap = idle_gap();
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (pending.size() > 0 &&
                         (!pending[0].wait_idle || sorted_due.size() == 0)) begin
                req = pending.pop_front();
                s_valid <= 1'b1;
                s_value <= req.value;
                s_last  <= req.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Drive m_ready with random stalls and one long hold mid-flush
    always @(negedge aclk) begin : drive_ready
        logic rdy;
        if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
            long_hold_done = 1'b1;
            ready_stall    = LONG_HOLD;
        end
        if (ready_stall > 0) begin
            ready_stall--;
            rdy = 1'b0;
        end else begin
            rdy         = 1'b1;
            ready_stall = idle_gap();
        end
        m_ready <= rdy;
    end

    // Abort on a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(negedge aclk);
        $display("** insertion_sorter: FAILED **");
        $finish;
    end

    initial begin
        int   set_len;
        int   kind;
        logic end_bit;
        logic sync_set;
        logic sync_done;
        logic first_set;

        s_valid        = 1'b0;
        s_value        = '0;
        s_last         = 1'b0;
        m_ready        = 1'b0;
        aresetn        = 1'b0;
        s_taken        = 1'b0;
        cycle_count    = 0;
        results_seen   = 0;
        fault_count    = 0;
        send_gap       = 0;
        ready_stall    = 0;
        long_hold_done = 1'b0;

        // Single-value sets at both extremes
        add_request({1'b0, {(WORD_W-1){1'b1}}}, 1'b1, 1'b0);
        add_request({1'b1, {(WORD_W-1){1'b0}}}, 1'b1, 1'b0);
        // Mixed extremes, most negative arrives last
        add_request(word_t'(0), 1'b0, 1'b0);
        add_request(word_t'(-1), 1'b0, 1'b0);
        add_request(word_t'(1), 1'b0, 1'b0);
        add_request({1'b0, {(WORD_W-1){1'b1}}}, 1'b0, 1'b0);
        add_request({1'b1, {(WORD_W-1){1'b0}}}, 1'b1, 1'b0);
        // Descending run: every insertion lands at position zero
        add_request(word_t'(30), 1'b0, 1'b0);
        add_request(word_t'(20), 1'b0, 1'b0);
        add_request(word_t'(10), 1'b0, 1'b0);
        add_request(word_t'(-10), 1'b1, 1'b0);
        // Equal values stay in arrival order
        add_request(word_t'(7), 1'b0, 1'b0);
        add_request(word_t'(7), 1'b0, 1'b0);
        add_request(word_t'(-7), 1'b0, 1'b0);
        add_request(word_t'(7), 1'b1, 1'b0);
        // Alternating bit patterns
        add_request(word_t'(32'h5555_5555), 1'b0, 1'b0);
        add_request(word_t'(32'hAAAA_AAAA), 1'b1, 1'b0);

        // Random sets; the first one fills the store without an end mark
        sync_done = 1'b0;
        first_set = 1'b1;
        while (pending.size() < ITEM_TARGET) begin
            kind = first_set ? 0 : $urandom_range(0, 19);
            if (kind == 0)
                set_len = SORT_DEPTH;
            else if (kind == 1)
                set_len = SORT_DEPTH + $urandom_range(1, 5);
            else
                set_len = $urandom_range(1, 12);
            sync_set = first_set || (!sync_done && pending.size() >= SYNC_POINT);
            for (int k = 0; k < set_len; k++) begin
                end_bit = 1'b0;
                if (k == set_len - 1)
                    end_bit = (kind == 0) ? (first_set ? 1'b0 : 1'(($urandom_range(0, 1))))
                                          : 1'b1;
                add_request(pick_value(), end_bit, sync_set && k == 0);
            end
            if (sync_set && !first_set)
                sync_done = 1'b1;
            first_set = 1'b0;
        end

        // Release reset
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for all requests, then all results, then watch for strays
        while (pending.size() != 0 || s_valid)
            @(negedge aclk);
        while (sorted_due.size() != 0)
            @(negedge aclk);
        repeat (2 * SORT_DEPTH + 20) @(negedge aclk);
        if (sorted_due.size() != 0) begin
            $error("%0d expected results never arrived", sorted_due.size());
            fault_count++;
        end

        if (fault_count == 0)
            $display("** insertion_sorter: PASSED **");
        else
            $display("** insertion_sorter: FAILED **");
        $finish;
    end

endmodule : insertion_sorter_tb
